// ----- rtl/haversine_distance_unit_defines.svh -----
// Assertion macros for the haversine distance unit
`ifndef HAVERSINE_DISTANCE_UNIT_DEFINES_SVH
`define HAVERSINE_DISTANCE_UNIT_DEFINES_SVH
// Check that a condition implies another in the next cycle
`define HDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hdu check failed");
// Check that a condition implies another in the same cycle
`define HDU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hdu check failed");
`endif

// ----- rtl/hdu_pkg.sv -----
// ----------------------------------------------------------------------------
// hdu_pkg
// Shared constants and helpers for the haversine distance unit.
// ----------------------------------------------------------------------------
`default_nettype none
package hdu_pkg;
  localparam int ANGLE_FRAC_BITS = 30;
  localparam int CORDIC_STAGES = 32;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] GAIN_Q62 = 64'd2800459870029451956;
  localparam logic [63:0] DIV_180 = 64'd3600000000;
  localparam logic [31:0] DIST_CAP = 32'd2199114858;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;
  localparam logic signed [33:0] HALF_90 = 34'sd1800000000;
  localparam logic signed [33:0] HALF_180 = 34'sd3600000000;

  // Split pi/180 degrees: PI_Q60 = PI_DIV_Q * DIV_180 + PI_DIV_R
  localparam logic [31:0] DIV_180_32 = 32'(DIV_180);
  localparam logic [31:0] PI_DIV_Q = 32'(PI_Q60 / DIV_180);
  localparam logic [31:0] PI_DIV_R = 32'(PI_Q60 % DIV_180);
  // Remainder part over the divisor, scaled by 2^32
  localparam logic [31:0] PI_DIV_RINV = 32'((64'(PI_DIV_R) << 32) / DIV_180);

  // Round a Q62 value to the given fraction bits
  function automatic logic signed [63:0] q62_to_f(input logic [63:0] v, input int f);
    logic [63:0] r;
    r = (v + (64'd1 << (61 - f))) >> (62 - f);
    return signed'(r);
  endfunction

  // CORDIC step angle atan(2^-i), series in Q62
  function automatic logic signed [63:0] atan_step(input int i, input int f);
    logic [63:0] sum;
    logic [63:0] term;
    int e;
    sum = 64'd0;
    if (i == 0) return q62_to_f(PI_Q60, f);
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return q62_to_f(sum, f);
  endfunction

  // Arithmetic shift with saturation to sign at wide shifts
  function automatic logic signed [63:0] asr(input logic signed [63:0] v, input int s);
    if (s >= 63) return v[63] ? -64'sd1 : 64'sd0;
    return v >>> s;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/hdu_sincos.sv -----
// ----------------------------------------------------------------------------
// hdu_sincos
// Pipelined angle conversion and rotation CORDIC for sin/cos of a half-unit angle.
// ----------------------------------------------------------------------------
`default_nettype none
module hdu_sincos #(
  parameter int FRAC = hdu_pkg::ANGLE_FRAC_BITS,
  parameter int STAGES = hdu_pkg::CORDIC_STAGES
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [33:0] angle,
  output logic signed [63:0]      sin_out,
  output logic signed [63:0]      cos_out
);
  // Conversion: fold, then floor(|h| * pi / 180 degrees) as a whole part
  // times |h| plus a reciprocal estimate of the remainder part, then round
  logic               flip0;
  logic [31:0]        mag0;
  logic               neg0;
  logic [63:0]        pq1, pr1, pe1;
  logic               flip1, neg1;
  logic [31:0]        qe2;
  logic [63:0]        qd2, pq2, pr2;
  logic               flip2, neg2;
  logic [63:0]        quo3;
  logic               flip3, neg3;
  logic signed [63:0] z4;
  logic               flip4;
  logic signed [33:0] folded;
  logic [63:0]        z_mag;

  always_comb begin
    folded = angle;
    if (angle > hdu_pkg::HALF_90) folded = hdu_pkg::HALF_180 - angle;
    else if (angle < -hdu_pkg::HALF_90) folded = -hdu_pkg::HALF_180 - angle;
    z_mag = (quo3 + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
  end

  // Advance the conversion stages
  always_ff @(posedge clk) begin
    if (en) begin
      flip0 <= (angle > hdu_pkg::HALF_90) || (angle < -hdu_pkg::HALF_90);
      neg0  <= folded[33];
      mag0  <= folded[33] ? 32'(-folded) : 32'(folded);
      pq1   <= 64'(mag0) * 64'(hdu_pkg::PI_DIV_Q);
      pr1   <= 64'(mag0) * 64'(hdu_pkg::PI_DIV_R);
      pe1   <= 64'(mag0) * 64'(hdu_pkg::PI_DIV_RINV);
      flip1 <= flip0;
      neg1  <= neg0;
      qe2   <= pe1[63:32];
      qd2   <= 64'(pe1[63:32]) * 64'(hdu_pkg::DIV_180_32);
      pq2   <= pq1;
      pr2   <= pr1;
      flip2 <= flip1;
      neg2  <= neg1;
      // The estimate is low by at most one; fix it from the remainder
      quo3  <= pq2 + 64'(qe2) + ((pr2 - qd2 >= hdu_pkg::DIV_180) ? 64'd1 : 64'd0);
      flip3 <= flip2;
      neg3  <= neg2;
      z4    <= neg3 ? -signed'(z_mag) : signed'(z_mag);
      flip4 <= flip3;
    end
  end

  // Rotation CORDIC, one micro-rotation per stage
  logic signed [63:0] xs [STAGES+1];
  logic signed [63:0] ys [STAGES+1];
  logic signed [63:0] zs [STAGES+1];
  logic               fs [STAGES+1];
  assign xs[0] = hdu_pkg::q62_to_f(hdu_pkg::GAIN_Q62, FRAC);
  assign ys[0] = 64'sd0;
  assign zs[0] = z4;
  assign fs[0] = flip4;

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [63:0] AT = hdu_pkg::atan_step(i, FRAC);
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - hdu_pkg::asr(ys[i], i);
          ys[i+1] <= ys[i] + hdu_pkg::asr(xs[i], i);
          zs[i+1] <= zs[i] - AT;
        end else begin
          xs[i+1] <= xs[i] + hdu_pkg::asr(ys[i], i);
          ys[i+1] <= ys[i] - hdu_pkg::asr(xs[i], i);
          zs[i+1] <= zs[i] + AT;
        end
        fs[i+1] <= fs[i];
      end
    end
  end

  assign sin_out = ys[STAGES];
  assign cos_out = fs[STAGES] ? -xs[STAGES] : xs[STAGES];
  logic unused_z;
  assign unused_z = zs[STAGES][0];
endmodule
`default_nettype wire

// ----- rtl/hdu_combine.sv -----
// ----------------------------------------------------------------------------
// hdu_combine
// Haversine term, two square roots and vectoring CORDIC for the central angle.
// ----------------------------------------------------------------------------
`default_nettype none
module hdu_combine #(
  parameter int FRAC = hdu_pkg::ANGLE_FRAC_BITS,
  parameter int STAGES = hdu_pkg::CORDIC_STAGES
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [63:0] sd,
  input  wire logic signed [63:0] so,
  input  wire logic signed [63:0] c1,
  input  wire logic signed [63:0] c2,
  output logic signed [63:0]      angle_c
);
  localparam logic signed [63:0] ONE = 64'sd1 << FRAC;
  localparam int SB = FRAC + 1;
  // Unit-range operands stay below 2^(FRAC+2) in magnitude
  localparam int MW = FRAC + 2;
  localparam int PW = 2 * MW;
  // Remainder width for the square roots of values up to 2^(2*FRAC)
  localparam int RW = 2 * FRAC + 2;

  function automatic logic signed [63:0] mulq(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [63:0] fa, fb;
    logic [MW-1:0] ma, mb;
    logic [PW-1:0] p, r;
    fa = a[63] ? 64'(-a) : 64'(a);
    fb = b[63] ? 64'(-b) : 64'(b);
    ma = fa[MW-1:0];
    mb = fb[MW-1:0];
    p = PW'(ma) * PW'(mb);
    r = (p + (PW'(1) << (FRAC - 1))) >> FRAC;
    return (a[63] != b[63]) ? -signed'(64'(r)) : signed'(64'(r));
  endfunction

  // Products in two stages
  logic signed [63:0] sd2, so2, cc, a_q, a_cl;
  logic signed [63:0] t;
  always_ff @(posedge clk) begin
    if (en) begin
      sd2 <= mulq(sd, sd);
      so2 <= mulq(so, so);
      cc  <= mulq(c1, c2);
      t   <= sd2;
      a_q <= mulq(cc, so2);
    end
  end
  always_comb begin
    a_cl = t + a_q;
    if (a_cl < 0) a_cl = 64'sd0;
    if (a_cl > ONE) a_cl = ONE;
  end

  // Bitwise square roots, one result bit per stage; keep the remainder
  // value minus root squared so each trial is a shift, add and compare
  logic [RW-1:0] ra [SB+1];
  logic [RW-1:0] rb [SB+1];
  logic [63:0]   qa [SB+1];
  logic [63:0]   qb [SB+1];
  logic signed [63:0] a_r;
  always_ff @(posedge clk) if (en) a_r <= a_cl;
  assign ra[0] = RW'(a_r) << FRAC;
  assign rb[0] = RW'(ONE - a_r) << FRAC;
  assign qa[0] = 64'd0;
  assign qb[0] = 64'd0;
  for (genvar k = 0; k < SB; k++) begin : g_sq
    localparam int B = FRAC - k;
    logic [RW-1:0] ta, tb;
    assign ta = (RW'(qa[k]) << (B + 1)) + (RW'(1) << (2 * B));
    assign tb = (RW'(qb[k]) << (B + 1)) + (RW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        ra[k+1] <= (ta <= ra[k]) ? ra[k] - ta : ra[k];
        rb[k+1] <= (tb <= rb[k]) ? rb[k] - tb : rb[k];
        qa[k+1] <= (ta <= ra[k]) ? (qa[k] | (64'd1 << B)) : qa[k];
        qb[k+1] <= (tb <= rb[k]) ? (qb[k] | (64'd1 << B)) : qb[k];
      end
    end
  end

  // Vectoring CORDIC
  logic signed [63:0] xv [STAGES+1];
  logic signed [63:0] yv [STAGES+1];
  logic signed [63:0] zv [STAGES+1];
  assign xv[0] = signed'(qb[SB]);
  assign yv[0] = signed'(qa[SB]);
  assign zv[0] = 64'sd0;
  for (genvar i = 0; i < STAGES; i++) begin : g_vec
    localparam logic signed [63:0] AT = hdu_pkg::atan_step(i, FRAC);
    always_ff @(posedge clk) begin
      if (en) begin
        if (yv[i] >= 0) begin
          xv[i+1] <= xv[i] + hdu_pkg::asr(yv[i], i);
          yv[i+1] <= yv[i] - hdu_pkg::asr(xv[i], i);
          zv[i+1] <= zv[i] + AT;
        end else begin
          xv[i+1] <= xv[i] - hdu_pkg::asr(yv[i], i);
          yv[i+1] <= yv[i] + hdu_pkg::asr(xv[i], i);
          zv[i+1] <= zv[i] - AT;
        end
      end
    end
  end

  // Double and clamp at zero
  always_ff @(posedge clk) begin
    if (en) angle_c <= zv[STAGES][63] ? 64'sd0 : (zv[STAGES] <<< 1);
  end
  logic unused_r;
  assign unused_r = ^{ra[SB], rb[SB], xv[STAGES], yv[STAGES]};
endmodule
`default_nettype wire

// ----- rtl/haversine_distance_unit.sv -----
// ----------------------------------------------------------------------------
// haversine_distance_unit
// Great-circle distance between two positions, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel in_valid/in_ready carries two latitude/longitude pairs in
//  units of 1e-7 degree. Output channel out_valid/out_ready returns one
//  distance_cm item per input item, in order.
//  Throughput: one item per cycle while the output is not stalled. The pipe
//  depth is set by the two unrolled CORDIC chains and the bit-per-stage
//  square root.
//  The whole pipe advances as one: when the output holds an item that is not
//  taken, every stage holds and in_ready drops. An empty output slot lets the
//  pipe move again.
//  Reset clears all valid bits and loads the radius register with 6371000 m.
//  cfg_we writes earth_radius_m; write it only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module haversine_distance_unit #(
  parameter int ANGLE_FRAC_BITS = hdu_pkg::ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES = hdu_pkg::CORDIC_STAGES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [22:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [30:0] first_lat,
  input  wire logic signed [31:0] first_lon,
  input  wire logic signed [30:0] second_lat,
  input  wire logic signed [31:0] second_lon,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             distance_cm
);
  localparam int DEPTH = 4 + CORDIC_STAGES + 1 + 3 + ANGLE_FRAC_BITS + 1
                         + CORDIC_STAGES + 1 + 2;
  // Central angle stays below 4 rad
  localparam int AW = ANGLE_FRAC_BITS + 2;
  localparam int PW = 30 + AW;
  logic en;
  logic [22:0] earth_radius_m;
  logic [DEPTH-1:0] vld;

  // Advance whenever the output slot is free or being drained
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) earth_radius_m <= hdu_pkg::RADIUS_RESET;
    else if (cfg_we) earth_radius_m <= cfg_wdata;
  end

  // Angle differences and doubled latitudes, as half-unit angles
  logic signed [33:0] a_dlat, a_dlon, a_l1, a_l2;
  assign a_dlat = 34'(second_lat) - 34'(first_lat);
  assign a_dlon = 34'(second_lon) - 34'(first_lon);
  assign a_l1 = 34'(first_lat) <<< 1;
  assign a_l2 = 34'(second_lat) <<< 1;

  logic signed [63:0] sd, cd, so, co, s1, c1, s2, c2, ang;
  hdu_sincos #(.FRAC(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES)) u_sc_d (
    .clk, .en, .angle(a_dlat), .sin_out(sd), .cos_out(cd));
  hdu_sincos #(.FRAC(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES)) u_sc_o (
    .clk, .en, .angle(a_dlon), .sin_out(so), .cos_out(co));
  hdu_sincos #(.FRAC(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES)) u_sc_1 (
    .clk, .en, .angle(a_l1), .sin_out(s1), .cos_out(c1));
  hdu_sincos #(.FRAC(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES)) u_sc_2 (
    .clk, .en, .angle(a_l2), .sin_out(s2), .cos_out(c2));

  hdu_combine #(.FRAC(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES)) u_comb (
    .clk, .en, .sd, .so, .c1, .c2, .angle_c(ang));

  // Radius in cm; stable while items are in flight only if the user writes it while idle
  logic [29:0] radius_cm;
  always_ff @(posedge clk) begin
    radius_cm <= 30'(earth_radius_m) * 30'd100;
  end

  // Scale by radius in cm, round, saturate
  logic [PW-1:0] dprod;
  logic [PW-1:0] dround;
  always_ff @(posedge clk) begin
    if (en) dprod <= PW'(radius_cm) * PW'(ang[AW-1:0]);
  end
  assign dround = (dprod + (PW'(1) << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
  always_ff @(posedge clk) begin
    if (en) distance_cm <= (dround > PW'(hdu_pkg::DIST_CAP)) ? hdu_pkg::DIST_CAP
                                                          : dround[31:0];
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_valid};
  end
  assign out_valid = vld[DEPTH-1];

  logic unused_c;
  assign unused_c = ^{cd, co, s1, s2, ang[63:AW]};
endmodule
`default_nettype wire

// ----- rtl/hdu_checker.sv -----
// ----------------------------------------------------------------------------
// hdu_checker
// Port-level checks for the haversine distance unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "haversine_distance_unit_defines.svh"
module hdu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] distance_cm
);
  `HDU_ASSERT_NOW(a_cap, out_valid, distance_cm <= hdu_pkg::DIST_CAP)
  `HDU_ASSERT_NOW(a_ready, !out_valid || out_ready, in_ready)
  `HDU_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(distance_cm))
endmodule
bind haversine_distance_unit hdu_checker u_chk (.clk, .rst, .in_ready, .out_valid,
  .out_ready, .distance_cm);
`default_nettype wire

// ----- tb/haversine_distance_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_checker
// Watches both channels of the haversine distance unit and checks every
// distance against a fixed-point prediction made from the accepted item.
// ----------------------------------------------------------------------------
module haversine_distance_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [22:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [30:0] first_lat,
  input  logic signed [31:0] first_lon,
  input  logic signed [30:0] second_lat,
  input  logic signed [31:0] second_lon,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [31:0]        distance_cm,
  output int                 fail_count,
  output int                 pending,
  output int                 checked_count
);
  localparam int FB = hdu_pkg::ANGLE_FRAC_BITS;
  localparam int NST = hdu_pkg::CORDIC_STAGES;
  localparam logic signed [63:0] UNIT_ONE = 64'sd1 <<< FB;

  logic [22:0] radius_m;
  logic [31:0] expected_dist [$];
  logic signed [63:0] step_angle [NST];

  // Round a Q62 constant down to the working fraction width
  function automatic logic signed [63:0] q62_round(input logic [63:0] v);
    return $signed((v + (64'd1 << (61 - FB))) >> (62 - FB));
  endfunction

  // Half units of 5e-8 degree to radians, truncated divide then rounded shift
  function automatic logic signed [63:0] half_to_rad(input logic signed [63:0] h);
    logic [63:0] mg;
    logic [127:0] prod;
    logic [63:0] q;
    mg = (h < 0) ? 64'(-h) : 64'(h);
    prod = {64'd0, mg} * {64'd0, hdu_pkg::PI_Q60};
    prod = prod / 128'd3600000000;
    q = prod[63:0];
    q = (q + (64'd1 << (59 - FB))) >> (60 - FB);
    return (h < 0) ? -$signed(q) : $signed(q);
  endfunction

  // Rounded fixed-point product, rounding on the magnitude
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [127:0] prod;
    logic [63:0] r;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    prod = {64'd0, ma} * {64'd0, mb};
    prod = (prod + (128'd1 << (FB - 1))) >> FB;
    r = prod[63:0];
    return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
  endfunction

  // Sine and cosine of a half-unit angle; fold past 90 degrees negates cos
  function automatic void rotate_sincos(input logic signed [63:0] h,
                                        output logic signed [63:0] s,
                                        output logic signed [63:0] c);
    logic flip;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    flip = 1'b0;
    if (h > 64'sd1800000000) begin
      h = 64'sd3600000000 - h;
      flip = 1'b1;
    end else if (h < -64'sd1800000000) begin
      h = -64'sd3600000000 - h;
      flip = 1'b1;
    end
    x = q62_round(hdu_pkg::GAIN_Q62);
    y = 64'sd0;
    z = half_to_rad(h);
    for (int i = 0; i < NST; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - step_angle[i];
      end else begin
        x = x + ys; y = y - xs; z = z + step_angle[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  // floor(sqrt(v * 2^FB)), one bit per pass
  function automatic logic signed [63:0] fx_sqrt(input logic signed [63:0] v);
    logic [127:0] target;
    logic [63:0] r;
    logic [63:0] t;
    target = {64'd0, v} << FB;
    r = 64'd0;
    for (int b = FB; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= target) r = t;
    end
    return $signed(r);
  endfunction

  // Vectoring CORDIC, angle of (x, y)
  function automatic logic signed [63:0] vector_angle(input logic signed [63:0] y,
                                                     input logic signed [63:0] x);
    logic signed [63:0] z;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    z = 64'sd0;
    for (int i = 0; i < NST; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + step_angle[i];
      end else begin
        x = x - ys; y = y + xs; z = z - step_angle[i];
      end
    end
    return z;
  endfunction

  // Great-circle distance in cm for one pair of positions
  function automatic logic [31:0] great_circle_cm(input logic signed [63:0] lat1,
                                                 input logic signed [63:0] lon1,
                                                 input logic signed [63:0] lat2,
                                                 input logic signed [63:0] lon2,
                                                 input logic [22:0] rad_m);
    logic signed [63:0] sd, cd, so, co, s1, c1, s2, c2, hav, ang;
    logic [127:0] prod;
    logic [63:0] d;
    rotate_sincos(lat2 - lat1, sd, cd);
    rotate_sincos(lon2 - lon1, so, co);
    rotate_sincos(2 * lat1, s1, c1);
    rotate_sincos(2 * lat2, s2, c2);
    hav = fx_mul(sd, sd) + fx_mul(fx_mul(c1, c2), fx_mul(so, so));
    if (hav < 0) hav = 64'sd0;
    if (hav > UNIT_ONE) hav = UNIT_ONE;
    ang = 2 * vector_angle(fx_sqrt(hav), fx_sqrt(UNIT_ONE - hav));
    if (ang < 0) ang = 64'sd0;
    prod = {64'd0, 64'(rad_m) * 64'd100} * {64'd0, 64'(ang)};
    prod = (prod + (128'd1 << (FB - 1))) >> FB;
    d = prod[63:0];
    if (d > 64'(hdu_pkg::DIST_CAP)) d = 64'(hdu_pkg::DIST_CAP);
    return d[31:0];
  endfunction

  // Build the step-angle table from the alternating arctangent series
  initial begin
    logic [63:0] sum;
    logic [63:0] term;
    for (int i = 0; i < NST; i++) begin
      if (i == 0) begin
        step_angle[i] = q62_round(hdu_pkg::PI_Q60);
      end else begin
        sum = 64'd0;
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
          term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
        step_angle[i] = q62_round(sum);
      end
    end
  end

  // Track the radius, predict on input, compare on output
  always @(posedge clk) begin
    if (rst) begin
      radius_m <= hdu_pkg::RADIUS_RESET;
      expected_dist.delete();
      fail_count <= 0;
      checked_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) radius_m <= cfg_wdata;
      if (in_valid && in_ready) begin
        expected_dist.push_back(great_circle_cm(first_lat, first_lon, second_lat,
                                                second_lon, radius_m));
      end
      if (out_valid && out_ready) begin
        if (expected_dist.size() == 0) begin
          $error("distance_cm: item with none expected, actual %0d", distance_cm);
          fail_count <= fail_count + 1;
        end else begin
          if (distance_cm !== expected_dist[0]) begin
            $error("distance_cm: expected %0d, actual %0d", expected_dist[0], distance_cm);
            fail_count <= fail_count + 1;
          end
          void'(expected_dist.pop_front());
          checked_count <= checked_count + 1;
        end
      end
      pending <= expected_dist.size();
    end
  end
endmodule

// ----- tb/haversine_distance_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_unit_tb
// Drives directed and random position pairs through the distance unit under
// several radius settings and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module haversine_distance_unit_tb;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 470;
  localparam int HOLD_CYCLES = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [22:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [30:0] first_lat = '0;
  logic signed [31:0] first_lon = '0;
  logic signed [30:0] second_lat = '0;
  logic signed [31:0] second_lon = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        distance_cm;

  int fail_count, pending, checked_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int items_sent = 0;

  haversine_distance_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_lat(first_lat), .first_lon(first_lon),
    .second_lat(second_lat), .second_lon(second_lon),
    .out_valid(out_valid), .out_ready(out_ready), .distance_cm(distance_cm)
  );

  haversine_distance_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_lat(first_lat), .first_lon(first_lon),
    .second_lat(second_lat), .second_lon(second_lon),
    .out_valid(out_valid), .out_ready(out_ready), .distance_cm(distance_cm),
    .fail_count(fail_count), .pending(pending), .checked_count(checked_count)
  );

  always #2 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      if (hold_left == HOLD_CYCLES) hold_done <= 1'b1;
      hold_left <= hold_left + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one item, idle at random first, hold until accepted
  task automatic send_pair(input logic signed [30:0] la1, input logic signed [31:0] lo1,
                           input logic signed [30:0] la2, input logic signed [31:0] lo2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_lat <= la1;
    first_lon <= lo1;
    second_lat <= la2;
    second_lon <= lo2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering, drain every expected distance, let the pipe settle
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [22:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [30:0] rand_lat();
    return 31'(longint'($urandom_range(32'd1800000000)) - 64'sd900000000);
  endfunction

  function automatic logic signed [31:0] rand_lon();
    return 32'(longint'($urandom_range(32'd3600000000)) - 64'sd1800000000);
  endfunction

  // Mostly in-range pairs, some close together, some degenerate, some raw bits
  task automatic send_random_pair();
    logic signed [30:0] la1, la2;
    logic signed [31:0] lo1, lo2;
    int pick;
    pick = $urandom_range(99);
    la1 = rand_lat();
    lo1 = rand_lon();
    la2 = rand_lat();
    lo2 = rand_lon();
    if (pick < 30) begin
      la2 = 31'(longint'(la1) + longint'($urandom_range(2000000)) - 1000000);
      lo2 = 32'(longint'(lo1) + longint'($urandom_range(2000000)) - 1000000);
    end else if (pick < 38) begin
      la2 = la1;
      lo2 = lo1;
    end else if (pick < 45) begin
      la2 = -la1;
      lo2 = (lo1 > 0) ? lo1 - 32'sd1800000000 : lo1 + 32'sd1800000000;
    end else if (pick < 60) begin
      la1 = 31'($urandom);
      lo1 = $urandom;
      la2 = 31'($urandom);
      lo2 = $urandom;
    end
    send_pair(la1, lo1, la2, lo2);
  endtask

  initial begin
    logic [22:0] radius_plan [4];
    int send_plan [4];
    int recv_plan [4];
    radius_plan = '{23'd6000000, 23'd7000000, 23'd8388607,
                    23'(6000000 + $urandom_range(1000000))};
    send_plan = '{10, 75, 0, 0};
    recv_plan = '{75, 10, 0, 0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset radius, field extremes and the special cases
    send_pair(0, 0, 0, 0);
    send_pair(31'sd900000000, 0, -31'sd900000000, 0);
    send_pair(0, -32'sd1800000000, 0, 32'sd1800000000);
    send_pair(0, 0, 0, 32'sd1800000000);
    send_pair(31'sd450000000, 32'sd100000000, -31'sd450000000, -32'sd1700000000);
    send_pair(31'sd900000000, 32'sd123456789, 31'sd900000000, -32'sd987654321);
    send_pair(-31'sd1073741824, -32'sd2147483648, 31'sd1073741823, 32'sd2147483647);
    send_pair(31'sd1073741823, 32'sd2147483647, -31'sd1073741824, -32'sd2147483648);
    send_pair(31'sd1000000000, 0, 31'sd1000000000, 32'sd5);
    send_pair(-31'sd1000000000, 32'sd2000000000, 31'sd200000000, -32'sd2000000000);
    send_pair(31'sd515000000, 32'sd1000000, 31'sd515000001, 32'sd1000001);
    send_pair(0, 0, 0, 32'sd1);
    send_pair(31'sd100, -32'sd100, -31'sd100, 32'sd100);
    send_pair(31'sd899999999, 32'sd1799999999, -31'sd899999999, -32'sd1);
    send_pair(-31'sd1, -32'sd1, -31'sd1, -32'sd1);
    send_pair(31'sd400000000, 32'sd2147483647, -31'sd400000000, -32'sd2147483648);
    drain_all();

    // Random phases, each under its own radius and idle pattern
    for (int p = 0; p < 4; p++) begin
      write_radius(radius_plan[p]);
      send_idle_pct = send_plan[p];
      recv_idle_pct = recv_plan[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 100) hold_go <= 1'b1;
        if (p == 3 && n == 200) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_random_pair();
      end
      drain_all();
    end

    $display("covered %0d items, %0d distances checked", items_sent, checked_count);
    $display("radius reset value, both range ends, the 23-bit maximum and a random value");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ----- haversine_distance_unit.f -----
+incdir+rtl
rtl/hdu_pkg.sv
rtl/hdu_sincos.sv
rtl/hdu_combine.sv
rtl/haversine_distance_unit.sv
rtl/hdu_checker.sv
tb/haversine_distance_checker.sv
tb/haversine_distance_unit_tb.sv
